FILE: design/aql_pkg.sv
// Shared constants, codes and types for the abortable queue lock manager.
// Used by the lock manager, its output stage and the test; depends on nothing.
`timescale 1ns / 1ps
package aql_pkg;

  localparam int AGENTS_DEF = 8;
  localparam int MAX_RES    = 8;
  localparam int AGENT_W    = 3;
  localparam int EV_W       = 3;
  localparam int KIND_W     = 2;
  localparam int TICK_W     = 32;

  localparam logic [KIND_W-1:0] KIND_ACQ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD  = 2'd3;

  localparam logic [EV_W-1:0] EV_QUEUED   = 3'd0;
  localparam logic [EV_W-1:0] EV_GRANTED  = 3'd1;
  localparam logic [EV_W-1:0] EV_ABORTED  = 3'd2;
  localparam logic [EV_W-1:0] EV_REJECTED = 3'd3;
  localparam logic [EV_W-1:0] EV_FREE     = 3'd4;
  localparam logic [EV_W-1:0] EV_NONE     = 3'd5;

  typedef struct packed {
    logic               defer;
    logic               fin;
    logic [AGENT_W-1:0] agent;
    logic [EV_W-1:0]    ev;
  } emit_t;

endpackage

FILE: design/abortable_queue_lock.sv
// Abortable FIFO queue lock manager: acquire, release, tick; order and counts in RAM.
// Acquire and invalid items: result in the cycle after accept, busy stays low.
// Release and tick: busy while the head check and order-RAM scan run (one order-RAM read per cycle,
// read/read/write-back scan); final result in the same cycle busy falls; receiver cannot stall.
// Synchronous reset empties the queue; RAM contents stay undefined until written.
// Depends on aql_pkg, aql_ram, aql_emit.
`timescale 1ns / 1ps
module abortable_queue_lock #(
  parameter int AGENTS = aql_pkg::AGENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [aql_pkg::KIND_W-1:0]    kind,
  input  logic [aql_pkg::AGENT_W-1:0]   agent,
  input  logic [aql_pkg::TICK_W-1:0]    patience,
  output logic                          result_valid,
  output logic [aql_pkg::AGENT_W-1:0]   target_agent,
  output logic [aql_pkg::EV_W-1:0]      event_res,
  output logic                          last
);
  import aql_pkg::*;

  localparam int IW = $clog2(AGENTS);
  localparam int LW = $clog2(AGENTS + 1);
  localparam int NW = $clog2(MAX_RES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CHK  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]         state, state_next;
  logic [LW-1:0]      qlen, qlen_next;
  logic [AGENTS-1:0]  flags, flags_next;
  logic               mode_rel, mode_rel_next;
  logic [AGENT_W-1:0] cmd_agent, cmd_agent_next;
  logic [LW-1:0]      rd_idx, rd_idx_next;
  logic [LW-1:0]      wr_idx, wr_idx_next;
  logic               s1_vld, s1_vld_next;
  logic               s2_vld, s2_vld_next;
  logic [AGENT_W-1:0] s2_agent, s2_agent_next;
  logic [NW-1:0]      n_ab, n_ab_next;
  logic [AGENT_W-1:0] first_agent, first_agent_next;

  logic               wo_we;
  logic [IW-1:0]      wo_waddr, wo_raddr;
  logic [AGENT_W-1:0] wo_wdata, wo_rdata;
  logic               rt_we;
  logic [IW-1:0]      rt_waddr, rt_raddr;
  logic [TICK_W-1:0]  rt_wdata, rt_rdata, t_dec;
  emit_t              emit;

  logic               accept, agent_ok, issue, drop;
  logic [IW-1:0]      agent_idx, s2_idx;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign agent_ok  = int'(agent) < AGENTS;
  assign agent_idx = IW'(agent);
  assign s2_idx    = IW'(s2_agent);
  assign issue     = (state == ST_SCAN) && (rd_idx < qlen);
  assign t_dec     = (rt_rdata != '1 && rt_rdata != '0) ? rt_rdata - TICK_W'(1) : rt_rdata;
  assign drop      = s2_vld && !mode_rel && (t_dec == '0) && (n_ab < NW'(MAX_RES));

  aql_ram #(.WIDTH(AGENT_W), .DEPTH(AGENTS)) u_order (
    .clk(clk), .we(wo_we), .waddr(wo_waddr), .wdata(wo_wdata),
    .raddr(wo_raddr), .rdata(wo_rdata)
  );

  aql_ram #(.WIDTH(TICK_W), .DEPTH(AGENTS)) u_ticks (
    .clk(clk), .we(rt_we), .waddr(rt_waddr), .wdata(rt_wdata),
    .raddr(rt_raddr), .rdata(rt_rdata)
  );

  aql_emit u_emit (
    .clk(clk), .rst(rst), .req(emit), .result_valid(result_valid),
    .target_agent(target_agent), .event_res(event_res), .last(last)
  );

  always_comb begin
    state_next       = state;
    qlen_next        = qlen;
    flags_next       = flags;
    mode_rel_next    = mode_rel;
    cmd_agent_next   = cmd_agent;
    rd_idx_next      = rd_idx;
    wr_idx_next      = wr_idx;
    s1_vld_next      = 1'b0;
    s2_vld_next      = 1'b0;
    s2_agent_next    = s2_agent;
    n_ab_next        = n_ab;
    first_agent_next = first_agent;
    wo_we            = 1'b0;
    wo_waddr         = '0;
    wo_wdata         = '0;
    wo_raddr         = '0;
    rt_we            = 1'b0;
    rt_waddr         = '0;
    rt_wdata         = '0;
    rt_raddr         = '0;
    emit             = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_ACQ: begin
              emit.fin   = 1'b1;
              emit.agent = agent;
              if (!agent_ok || flags[agent_idx]) begin
                emit.ev = EV_REJECTED;
              end else if (qlen == '0) begin
                wo_we                 = 1'b1;
                wo_waddr              = '0;
                wo_wdata              = agent;
                qlen_next             = LW'(1);
                flags_next[agent_idx] = 1'b1;
                emit.ev               = EV_GRANTED;
              end else if (patience <= TICK_W'(1)) begin
                emit.ev = EV_ABORTED;
              end else begin
                wo_we                 = 1'b1;
                wo_waddr              = IW'(qlen);
                wo_wdata              = agent;
                rt_we                 = 1'b1;
                rt_waddr              = agent_idx;
                rt_wdata              = (patience == '1) ? '1 : patience - TICK_W'(1);
                qlen_next             = qlen + LW'(1);
                flags_next[agent_idx] = 1'b1;
                emit.ev               = EV_QUEUED;
              end
            end
            KIND_REL: begin
              if (!agent_ok || qlen == '0) begin
                emit.fin   = 1'b1;
                emit.agent = agent;
                emit.ev    = EV_REJECTED;
              end else begin
                wo_raddr       = '0;
                cmd_agent_next = agent;
                state_next     = ST_CHK;
              end
            end
            KIND_TICK: begin
              mode_rel_next = 1'b0;
              rd_idx_next   = LW'(1);
              wr_idx_next   = LW'(1);
              n_ab_next     = '0;
              state_next    = ST_SCAN;
            end
            default: begin
              emit.fin   = 1'b1;
              emit.agent = agent;
              emit.ev    = EV_REJECTED;
            end
          endcase
        end
      end
      ST_CHK: begin
        if (wo_rdata != cmd_agent) begin
          emit.fin   = 1'b1;
          emit.agent = cmd_agent;
          emit.ev    = EV_REJECTED;
          state_next = ST_IDLE;
        end else begin
          flags_next[IW'(cmd_agent)] = 1'b0;
          mode_rel_next              = 1'b1;
          rd_idx_next                = LW'(1);
          wr_idx_next                = '0;
          n_ab_next                  = '0;
          state_next                 = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // stage 1: read order entry
        if (issue) begin
          wo_raddr    = IW'(rd_idx);
          rd_idx_next = rd_idx + LW'(1);
          s1_vld_next = 1'b1;
        end
        // stage 2: read that agent's count
        if (s1_vld) begin
          rt_raddr      = IW'(wo_rdata);
          s2_vld_next   = 1'b1;
          s2_agent_next = wo_rdata;
        end
        // stage 3: count down and drop (tick only), or compact
        if (s2_vld) begin
          if (!mode_rel) begin
            rt_we    = 1'b1;
            rt_waddr = s2_idx;
            rt_wdata = t_dec;
          end
          if (drop) begin
            flags_next[s2_idx] = 1'b0;
            n_ab_next          = n_ab + NW'(1);
            emit.defer         = 1'b1;
            emit.agent         = s2_agent;
            emit.ev            = EV_ABORTED;
          end else begin
            wo_we       = 1'b1;
            wo_waddr    = IW'(wr_idx);
            wo_wdata    = s2_agent;
            wr_idx_next = wr_idx + LW'(1);
            if (wr_idx == '0) begin
              first_agent_next = s2_agent;
            end
          end
        end
        if (!issue && !s1_vld && !s2_vld) begin
          state_next = ST_IDLE;
          emit.fin   = 1'b1;
          if (mode_rel) begin
            qlen_next  = wr_idx;
            emit.agent = (wr_idx != '0) ? first_agent : cmd_agent;
            emit.ev    = (wr_idx != '0) ? EV_GRANTED : EV_FREE;
          end else begin
            qlen_next  = (qlen != '0) ? wr_idx : '0;
            emit.agent = '0;
            emit.ev    = EV_NONE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      qlen   <= '0;
      flags  <= '0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      state  <= state_next;
      qlen   <= qlen_next;
      flags  <= flags_next;
      s1_vld <= s1_vld_next;
      s2_vld <= s2_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    mode_rel    <= mode_rel_next;
    cmd_agent   <= cmd_agent_next;
    rd_idx      <= rd_idx_next;
    wr_idx      <= wr_idx_next;
    s2_agent    <= s2_agent_next;
    n_ab        <= n_ab_next;
    first_agent <= first_agent_next;
  end

`ifndef SYNTHESIS
  a_flags_match_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ($countones(flags) == int'(qlen)))
    else $error("in-queue flags disagree with queue length");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    int'(qlen) <= AGENTS)
    else $error("queue length beyond agent count");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!s1_vld && !s2_vld))
    else $error("scan pipeline active while idle");

  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == KIND_ACQ || kind == KIND_BAD)) |=> (result_valid && last))
    else $error("acquire or invalid item gave no final result");

  a_busy_end_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (result_valid && last))
    else $error("long item ended without a final result");
`endif

endmodule

FILE: design/aql_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
module aql_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/aql_emit.sv
// Result output stage: holds one deferred result so the final one carries last.
// Depends on aql_pkg for the request struct and field widths.
`timescale 1ns / 1ps
module aql_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  aql_pkg::emit_t                req,
  output logic                          result_valid,
  output logic [aql_pkg::AGENT_W-1:0]   target_agent,
  output logic [aql_pkg::EV_W-1:0]      event_res,
  output logic                          last
);
  import aql_pkg::*;

  logic               held_vld;
  logic [AGENT_W-1:0] held_agent;
  logic [EV_W-1:0]    held_ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      held_vld     <= 1'b0;
    end else begin
      result_valid <= req.fin || (req.defer && held_vld);
      if (req.fin) begin
        held_vld <= 1'b0;
      end else if (req.defer) begin
        held_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.fin) begin
      target_agent <= held_vld ? held_agent : req.agent;
      event_res    <= held_vld ? held_ev : req.ev;
      last         <= 1'b1;
    end else if (req.defer) begin
      target_agent <= held_agent;
      event_res    <= held_ev;
      last         <= 1'b0;
      held_agent   <= req.agent;
      held_ev      <= req.ev;
    end
  end

endmodule

FILE: verif/abortable_queue_lock_test.sv
// Self-checking test of abortable_queue_lock: directed and random acquire, release, tick and invalid
// items, each checked against a queue-lock tracker kept inside the test.
// Depends on aql_pkg and the abortable_queue_lock RTL.
`timescale 1ns / 1ps
module abortable_queue_lock_test;
  import aql_pkg::*;

  localparam logic [TICK_W-1:0] WAIT_FOREVER = '1;
  localparam int LIMIT = 200000;
  localparam int PHASE_ITEMS = 86;

  typedef struct {
    logic [AGENT_W-1:0] agent;
    logic [EV_W-1:0]    ev;
    logic               last;
  } lock_event_t;

  class lock_tracker;
    logic [AGENT_W-1:0] line_up[AGENTS_DEF];
    logic [TICK_W-1:0]  ticks_left[AGENTS_DEF];
    bit                 queued[AGENTS_DEF];
    int unsigned        line_len;
    lock_event_t        pending[$];
    int                 errors;

    function new();
      line_len = 0;
      errors = 0;
      foreach (queued[i]) queued[i] = 1'b0;
    endfunction

    function void add(logic [AGENT_W-1:0] a, logic [EV_W-1:0] ev);
      lock_event_t e;
      e.agent = a;
      e.ev = ev;
      e.last = 1'b0;
      pending.push_back(e);
    endfunction

    function void note_request(logic [KIND_W-1:0] k, logic [AGENT_W-1:0] a,
                               logic [TICK_W-1:0] p);
      int unsigned kept;
      int n;
      logic [AGENT_W-1:0] w;
      logic [TICK_W-1:0] t;
      n = 0;
      case (k)
        KIND_ACQ: begin
          if (queued[a]) begin
            add(a, EV_REJECTED);
          end else if (line_len == 0) begin
            line_up[0] = a;
            line_len = 1;
            queued[a] = 1'b1;
            add(a, EV_GRANTED);
          end else if (p <= 1) begin
            add(a, EV_ABORTED);
          end else begin
            line_up[line_len] = a;
            line_len++;
            queued[a] = 1'b1;
            ticks_left[a] = (p == WAIT_FOREVER) ? WAIT_FOREVER : p - 1;
            add(a, EV_QUEUED);
          end
        end
        KIND_REL: begin
          if (line_len == 0 || line_up[0] != a) begin
            add(a, EV_REJECTED);
          end else begin
            queued[a] = 1'b0;
            for (int r = 1; r < line_len; r++) line_up[r-1] = line_up[r];
            line_len--;
            if (line_len > 0) add(line_up[0], EV_GRANTED);
            else add(a, EV_FREE);
          end
        end
        KIND_TICK: begin
          kept = 1;
          for (int r = 1; r < line_len; r++) begin
            w = line_up[r];
            t = ticks_left[w];
            if (t != WAIT_FOREVER && t != 0) t--;
            ticks_left[w] = t;
            if (t == 0 && n < MAX_RES) begin
              queued[w] = 1'b0;
              add(w, EV_ABORTED);
              n++;
            end else begin
              line_up[kept] = w;
              kept++;
            end
          end
          if (line_len > 0) line_len = kept;
          if (n == 0) add('0, EV_NONE);
        end
        default: begin
          add(a, EV_REJECTED);
        end
      endcase
      pending[pending.size()-1].last = 1'b1;
    endfunction

    function void check_event(logic [AGENT_W-1:0] a, logic [EV_W-1:0] ev, logic l);
      lock_event_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result agent=%0d event=%0d last=%0d", $time, a, ev, l);
        errors++;
      end else begin
        e = pending.pop_front();
        if (e.agent !== a) begin
          $display("%0t: target_agent expected %0d got %0d", $time, e.agent, a);
          errors++;
        end
        if (e.ev !== ev) begin
          $display("%0t: event_res expected %0d got %0d", $time, e.ev, ev);
          errors++;
        end
        if (e.last !== l) begin
          $display("%0t: last expected %0d got %0d", $time, e.last, l);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [KIND_W-1:0] kind = '0;
  logic [AGENT_W-1:0] agent = '0;
  logic [TICK_W-1:0] patience = '0;
  logic result_valid;
  logic [AGENT_W-1:0] target_agent;
  logic [EV_W-1:0] event_res;
  logic last;

  lock_tracker trk = new();
  int cycles = 0;

  abortable_queue_lock uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .agent(agent),
    .patience(patience),
    .result_valid(result_valid),
    .target_agent(target_agent),
    .event_res(event_res),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && result_valid) trk.check_event(target_agent, event_res, last);
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // hold the item until accepted, then idle with the given chance per cycle
  task automatic send_item(logic [KIND_W-1:0] k, logic [AGENT_W-1:0] a,
                           logic [TICK_W-1:0] p, int idle_pct);
    start <= 1'b1;
    kind <= k;
    agent <= a;
    patience <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    trk.note_request(k, a, p);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  initial begin
    int idle_pct[4] = '{0, 88, 0, 22};
    int sel;
    int ps;
    logic [KIND_W-1:0] k;
    logic [AGENT_W-1:0] a;
    logic [TICK_W-1:0] p;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(KIND_TICK, 3'd5, 32'd0, 0);
    send_item(KIND_REL, 3'd0, 32'd0, 0);
    send_item(KIND_ACQ, 3'd0, 32'd0, 0);
    send_item(KIND_ACQ, 3'd0, 32'd9, 0);
    send_item(KIND_ACQ, 3'd7, 32'd0, 0);
    send_item(KIND_ACQ, 3'd7, 32'd1, 0);
    send_item(KIND_ACQ, 3'd7, 32'd2, 0);
    send_item(KIND_ACQ, 3'd1, WAIT_FOREVER, 0);
    send_item(KIND_ACQ, 3'd2, 32'hFFFF_FFFE, 0);
    send_item(KIND_ACQ, 3'd3, 32'd3, 0);
    send_item(KIND_REL, 3'd7, 32'd0, 0);
    send_item(KIND_BAD, 3'd5, 32'hA5A5_5A5A, 0);
    send_item(KIND_TICK, 3'd0, 32'd0, 0);
    send_item(KIND_TICK, 3'd7, WAIT_FOREVER, 0);
    send_item(KIND_REL, 3'd0, 32'd0, 0);
    send_item(KIND_REL, 3'd1, 32'd0, 0);
    send_item(KIND_REL, 3'd2, 32'd0, 0);
    send_item(KIND_ACQ, 3'd0, WAIT_FOREVER, 0);
    for (int i = 1; i < AGENTS_DEF; i++) send_item(KIND_ACQ, i[AGENT_W-1:0], 32'd2, 0);
    send_item(KIND_TICK, 3'd0, 32'd0, 0);
    send_item(KIND_REL, 3'd0, 32'd0, 0);

    foreach (idle_pct[ph]) begin
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        sel = $urandom_range(99);
        ps = $urandom_range(9);
        a = AGENT_W'($urandom_range(AGENTS_DEF - 1));
        if (ps < 5) p = $urandom_range(12);
        else if (ps < 7) p = WAIT_FOREVER;
        else p = $urandom();
        if (sel < 40) begin
          k = KIND_ACQ;
        end else if (sel < 60) begin
          k = KIND_REL;
          if (trk.line_len > 0) a = trk.line_up[0];
        end else if (sel < 88) begin
          k = KIND_TICK;
        end else if (sel < 94) begin
          k = KIND_REL;
        end else begin
          k = KIND_BAD;
        end
        send_item(k, a, p, idle_pct[ph]);
      end
    end
    start <= 1'b0;

    while (trk.pending.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (trk.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
